@@ rtl/lcgr_pkg.sv @@
// Shared types and constants for the linear congruential generator.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps

package lcgr_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DATA_W - 1);

    localparam logic [DATA_W-1:0] MULT_MS    = 32'd214013;
    localparam logic [DATA_W-1:0] INCR_MS    = 32'd2531011;
    localparam logic [DATA_W-1:0] MULT_ANSI  = 32'd1103515245;
    localparam logic [DATA_W-1:0] INCR_ANSI  = 32'd12345;

    localparam logic [1:0] GSEL_MS     = 2'd1;
    localparam logic [1:0] GSEL_ANSI   = 2'd2;
    localparam logic [1:0] GSEL_ANSI31 = 2'd3;

    localparam logic [1:0] MODE_SEED  = 2'd0;
    localparam logic [1:0] MODE_RAW   = 2'd1;
    localparam logic [1:0] MODE_LIMIT = 2'd2;
    localparam logic [1:0] MODE_RANGE = 2'd3;

    localparam logic [1:0] CFG_GSEL  = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_LOW   = 2'd2;
    localparam logic [1:0] CFG_HIGH  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OFFS,
        ST_FIN
    } lcgr_state_t;

endpackage

@@ rtl/lcgr_cmd_if.sv @@
// Command channel: a draw or reseed request with its seed word.
// Depends on lcgr_pkg.
`timescale 1ns / 1ps

interface lcgr_cmd_if
    import lcgr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [DATA_W-1:0] seed_value;

    modport source (output valid, output mode, output seed_value, input ready);
    modport sink (input valid, input mode, input seed_value, output ready);
endinterface

@@ rtl/lcgr_rsp_if.sv @@
// Result channel: one drawn word and the empty-range flag.
// Depends on lcgr_pkg.
`timescale 1ns / 1ps

interface lcgr_rsp_if
    import lcgr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic              empty_range;

    modport source (output valid, output value, output empty_range, input ready);
    modport sink (input valid, input value, input empty_range, output ready);
endinterface

@@ rtl/lcg_random_with_range_reduction.sv @@
// Linear congruential generator with limit and range reduction, top level.
// Depends on lcgr_pkg, lcgr_cmd_if and lcgr_rsp_if.
`timescale 1ns / 1ps

// A reseed is taken while idle and returns no word. A draw advances the
// state with a shift-add multiplier that handles one multiplier bit per
// cycle, then, for limit and range draws, reduces it with a restoring
// remainder unit that takes one dividend bit per cycle, and for range draws
// adds the range offset in a further state. A raw draw, or a limit draw with
// the full limit, goes from the multiplier straight to the finishing state.
// An empty range goes from acceptance straight to the finishing state
// without touching the generator state. One item is worked on at a time,
// and a finished word waits in an output register while the next item is
// accepted; a finished word that finds that register still occupied holds
// off the next item until the receiver takes the waiting word.

module lcg_random_with_range_reduction
    import lcgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    lcgr_cmd_if.sink          cmd,
    lcgr_rsp_if.source        rsp
);

    lcgr_state_t       st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        gsel_reg, gsel_next;
    logic [DATA_W-1:0] limit_reg, limit_next;
    logic [DATA_W-1:0] low_reg, low_next;
    logic [DATA_W-1:0] high_reg, high_next;
    logic [DATA_W-1:0] gen_reg, gen_next;
    logic              need_div_reg, need_div_next;
    logic              use_offs_reg, use_offs_next;
    logic              mask31_reg, mask31_next;
    logic              out_valid_reg, out_valid_next;

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] mplier_reg, mplier_next;
    logic [DATA_W-1:0] mcand_reg, mcand_next;
    logic [DATA_W:0]   divisor_reg, divisor_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              empty_reg, empty_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_empty_reg, out_empty_next;

    logic [DATA_W-1:0] mult_sel, incr_sel, acc_sum, acc_masked;
    logic [DATA_W:0]   trial, trial_diff, span;
    logic              range_empty, out_free;

    always_comb
    begin
        unique case (gsel_reg)
            GSEL_ANSI, GSEL_ANSI31:
            begin
                mult_sel = MULT_ANSI;
                incr_sel = INCR_ANSI;
            end
            default:
            begin
                mult_sel = MULT_MS;
                incr_sel = INCR_MS;
            end
        endcase
    end

    assign range_empty = $signed(low_reg) > $signed(high_reg);
    assign span = {high_reg[DATA_W-1], high_reg} - {low_reg[DATA_W-1], low_reg}
                  + (DATA_W+1)'(1);
    assign acc_sum = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign acc_masked = mask31_reg ? {1'b0, acc_sum[DATA_W-2:0]} : acc_sum;
    assign trial = {rem_reg, mplier_reg[DATA_W-1]};
    assign trial_diff = trial - divisor_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    assign cmd.ready = (st_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;
    assign rsp.empty_range = out_empty_reg;

    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        gsel_next      = gsel_reg;
        limit_next     = limit_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        gen_next       = gen_reg;
        need_div_next  = need_div_reg;
        use_offs_next  = use_offs_reg;
        mask31_next    = mask31_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        acc_next       = acc_reg;
        mplier_next    = mplier_reg;
        mcand_next     = mcand_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        empty_next     = empty_reg;
        out_value_next = out_value_reg;
        out_empty_next = out_empty_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GSEL:  gsel_next  = cfg_data[1:0];
                CFG_LIMIT: limit_next = cfg_data;
                CFG_LOW:   low_next   = cfg_data;
                CFG_HIGH:  high_next  = cfg_data;
                default:   gsel_next  = gsel_reg;
            endcase
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    acc_next      = incr_sel;
                    mplier_next   = gen_reg;
                    mcand_next    = mult_sel;
                    cnt_next      = '0;
                    mask31_next   = (gsel_reg == GSEL_ANSI31);
                    use_offs_next = (cmd.mode == MODE_RANGE);
                    empty_next    = 1'b0;
                    need_div_next = (cmd.mode == MODE_RANGE) ||
                                    ((cmd.mode == MODE_LIMIT) && (~limit_reg != '0));
                    divisor_next  = (cmd.mode == MODE_RANGE) ? span
                                    : {1'b0, limit_reg} + (DATA_W+1)'(1);
                    if (cmd.mode == MODE_SEED)
                    begin
                        gen_next = cmd.seed_value;
                    end
                    else if ((cmd.mode == MODE_RANGE) && range_empty)
                    begin
                        res_next   = '0;
                        empty_next = 1'b1;
                        st_next    = ST_FIN;
                    end
                    else
                    begin
                        st_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next    = acc_sum;
                mplier_next = mplier_reg >> 1;
                mcand_next  = mcand_reg << 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == STEP_LAST)
                begin
                    gen_next    = acc_masked;
                    mplier_next = acc_masked;
                    res_next    = acc_masked;
                    rem_next    = '0;
                    cnt_next    = '0;
                    st_next     = need_div_reg ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV:
            begin
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                rem_next    = trial_diff[DATA_W] ? trial[DATA_W-1:0]
                                                 : trial_diff[DATA_W-1:0];
                if (cnt_reg == STEP_LAST)
                begin
                    st_next = ST_OFFS;
                end
            end
            ST_OFFS:
            begin
                res_next = rem_reg + (use_offs_reg ? low_reg : '0);
                st_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_empty_next = empty_reg;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cnt_reg       <= '0;
            gsel_reg      <= GSEL_MS;
            limit_reg     <= '1;
            low_reg       <= '0;
            high_reg      <= {1'b0, {(DATA_W-1){1'b1}}};
            gen_reg       <= '0;
            need_div_reg  <= 1'b0;
            use_offs_reg  <= 1'b0;
            mask31_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            gsel_reg      <= gsel_next;
            limit_reg     <= limit_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            gen_reg       <= gen_next;
            need_div_reg  <= need_div_next;
            use_offs_reg  <= use_offs_next;
            mask31_reg    <= mask31_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        mplier_reg    <= mplier_next;
        mcand_reg     <= mcand_next;
        divisor_reg   <= divisor_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        empty_reg     <= empty_next;
        out_value_reg <= out_value_next;
        out_empty_reg <= out_empty_next;
    end

    // An empty range always comes out as a zero word.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_value_reg == '0))
        else $error("empty range word is not zero");

    // A new word is loaded only from the finishing state.
    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(st_reg) == ST_FIN))
        else $error("output word loaded outside the finishing state");

    // Every multiply starts from step zero.
    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_MUL && $past(st_reg) == ST_IDLE) |-> (cnt_reg == '0))
        else $error("multiply started at a nonzero step");

    // The remainder pass either continues or hands over to the offset add.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DIV) |=> (st_reg == ST_DIV || st_reg == ST_OFFS))
        else $error("remainder pass left by an unexpected path");

endmodule
